// File: hw/rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the postfix expression evaluator: token
// kinds, error codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned ITER_W          = 6;
  localparam int unsigned DIV_STEPS       = 32;
  localparam int unsigned FACT_LIMIT      = 34;

  typedef enum logic [2:0] {
    TK_NUM  = 3'd0,
    TK_ADD  = 3'd1,
    TK_SUB  = 3'd2,
    TK_MUL  = 3'd3,
    TK_DIV  = 3'd4,
    TK_FACT = 3'd5
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV0     = 2'd1,
    ERR_NEGFACT  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POPR_RD,
    S_POPR_CAP,
    S_POPL_RD,
    S_POPL_CAP,
    S_EXEC,
    S_DIV,
    S_DIV_FIX,
    S_FACT_CHK,
    S_FACT,
    S_PUSH,
    S_FINISH,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_POP,
    DP_PEEK,
    DP_CAP_R,
    DP_CAP_L,
    DP_ALU,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_FIX,
    DP_FACT_INIT,
    DP_FACT_STEP,
    DP_PUSH,
    DP_ERR_DIV0,
    DP_ERR_NEGF,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    tok_kind_e kind;
    logic      last;
    logic      err_set;
    logic      div_zero;
    logic      fact_neg;
    logic      div_last;
    logic      fact_done;
    logic      out_free;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
    mag32 = v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// File: hw/rtl/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// rpn_ctrl
// Token sequencer: walks each item through operand pops, the arithmetic
// step, the push and the end-of-expression read-out.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpn_pkg::dp_status_t status_i,
  output rpn_pkg::ctrl_cmd_t cmd_o
);
  import rpn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (status_i.err_set) begin
          state_d = S_FINISH;
        end else begin
          case (status_i.kind)
            TK_NUM:  state_d = S_PUSH;
            TK_ADD:  state_d = S_POPR_RD;
            TK_SUB:  state_d = S_POPR_RD;
            TK_MUL:  state_d = S_POPR_RD;
            TK_DIV:  state_d = S_POPR_RD;
            TK_FACT: state_d = S_POPR_RD;
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_POPR_RD:  state_d = S_POPR_CAP;
      S_POPR_CAP: state_d = (status_i.kind == TK_FACT) ? S_FACT_CHK : S_POPL_RD;
      S_POPL_RD:  state_d = S_POPL_CAP;
      S_POPL_CAP: state_d = S_EXEC;
      S_EXEC: begin
        if (status_i.kind == TK_DIV) begin
          state_d = status_i.div_zero ? S_FINISH : S_DIV;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_DIV: begin
        if (status_i.div_last) state_d = S_DIV_FIX;
      end
      S_DIV_FIX:  state_d = S_PUSH;
      S_FACT_CHK: state_d = status_i.fact_neg ? S_FINISH : S_FACT;
      S_FACT: begin
        if (status_i.fact_done) state_d = S_PUSH;
      end
      S_PUSH:     state_d = S_FINISH;
      S_FINISH:   state_d = status_i.last ? S_OUT : S_IDLE;
      S_OUT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = DP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      S_POPR_RD:  cmd_o.op = DP_POP;
      S_POPR_CAP: cmd_o.op = DP_CAP_R;
      S_POPL_RD:  cmd_o.op = DP_POP;
      S_POPL_CAP: cmd_o.op = DP_CAP_L;
      S_EXEC: begin
        if (status_i.kind == TK_DIV) begin
          cmd_o.op = status_i.div_zero ? DP_ERR_DIV0 : DP_DIV_INIT;
        end else begin
          cmd_o.op = DP_ALU;
        end
      end
      S_DIV:      cmd_o.op = DP_DIV_STEP;
      S_DIV_FIX:  cmd_o.op = DP_DIV_FIX;
      S_FACT_CHK: cmd_o.op = status_i.fact_neg ? DP_ERR_NEGF : DP_FACT_INIT;
      S_FACT: begin
        if (!status_i.fact_done) cmd_o.op = DP_FACT_STEP;
      end
      S_PUSH:     cmd_o.op = DP_PUSH;
      S_FINISH: begin
        if (status_i.last) cmd_o.op = DP_PEEK;
      end
      S_OUT: begin
        if (status_i.out_free) cmd_o.op = DP_OUT;
      end
      default:    cmd_o.op = DP_NONE;
    endcase
  end

endmodule

// File: hw/rtl/rpn_dpath.sv
// ----------------------------------------------------------------------------
// rpn_dpath
// Operand stack memory, token and operand registers, shared arithmetic
// (add, subtract, multiply, radix-2 divider, factorial multiply loop) and
// the output register.
// ----------------------------------------------------------------------------
module rpn_dpath #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpn_pkg::ctrl_cmd_t  cmd_i,
  output rpn_pkg::dp_status_t status_o,
  input  logic [2:0]          kind_i,
  input  logic signed [31:0]  token_value_i,
  input  logic                last_token_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  answer_o,
  output logic [1:0]          status_out_o
);
  import rpn_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem [STACK_DEPTH];

  tok_kind_e         kind_q;
  logic              last_q;
  logic [CW-1:0]     count_q;
  err_e              err_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              empty_q;
  logic [WORD_W-1:0] right_q, left_q, res_q;
  logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
  logic              neg_q;
  logic [ITER_W-1:0] it_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] answer_q;
  err_e              status_q;

  logic [CW-1:0]     count_m1;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              full;
  logic [WORD_W:0]   rem_sh, rem_diff;
  logic              fact_big;
  logic [WORD_W-1:0] alu_res;

  assign count_m1 = count_q - 1'b1;
  assign rd_addr  = count_m1[AW-1:0];
  assign wr_addr  = count_q[AW-1:0];
  assign full     = (count_q == CW'(STACK_DEPTH));
  assign rem_sh   = {rem_q, quo_q[WORD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign fact_big = (right_q >= WORD_W'(FACT_LIMIT));

  always_comb begin
    case (kind_q)
      TK_ADD:  alu_res = left_q + right_q;
      TK_SUB:  alu_res = left_q - right_q;
      TK_MUL:  alu_res = WORD_W'(left_q * right_q);
      default: alu_res = '0;
    endcase
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_PUSH && !full) begin
      mem[wr_addr] <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_POP || cmd_i.op == DP_PEEK) begin
      rd_data_q <= mem[rd_addr];
      empty_q   <= (count_q == '0);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_POP: begin
          if (count_q != '0) count_q <= count_m1;
        end
        DP_PUSH: begin
          if (full) err_q <= ERR_OVERFLOW;
          else      count_q <= count_q + 1'b1;
        end
        DP_ERR_DIV0: err_q <= ERR_DIV0;
        DP_ERR_NEGF: err_q <= ERR_NEGFACT;
        DP_OUT: begin
          count_q <= '0;
          err_q   <= ERR_NONE;
        end
        default: ;
      endcase
      if (cmd_i.op == DP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        kind_q  <= tok_kind_e'(kind_i);
        last_q  <= last_token_i;
        res_q   <= token_value_i;
      end
      DP_CAP_R: right_q <= empty_q ? '1 : rd_data_q;
      DP_CAP_L: left_q  <= empty_q ? '1 : rd_data_q;
      DP_ALU:   res_q   <= alu_res;
      DP_DIV_INIT: begin
        rem_q <= '0;
        quo_q <= mag32(left_q);
        dvs_q <= mag32(right_q);
        neg_q <= left_q[WORD_W-1] ^ right_q[WORD_W-1];
        it_q  <= '0;
      end
      DP_DIV_STEP: begin
        if (!rem_diff[WORD_W]) begin
          rem_q <= rem_diff[WORD_W-1:0];
          quo_q <= {quo_q[WORD_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[WORD_W-1:0];
          quo_q <= {quo_q[WORD_W-2:0], 1'b0};
        end
        it_q <= it_q + 1'b1;
      end
      DP_DIV_FIX: res_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
      DP_FACT_INIT: begin
        res_q <= fact_big ? '0 : WORD_W'(1);
        it_q  <= ITER_W'(2);
      end
      DP_FACT_STEP: begin
        res_q <= WORD_W'(res_q * {{(WORD_W-ITER_W){1'b0}}, it_q});
        it_q  <= it_q + 1'b1;
      end
      DP_OUT: begin
        status_q <= err_q;
        if (err_q != ERR_NONE) answer_q <= '0;
        else if (empty_q)      answer_q <= '1;
        else                   answer_q <= rd_data_q;
      end
      default: ;
    endcase
  end

  assign status_o.kind      = kind_q;
  assign status_o.last      = last_q;
  assign status_o.err_set   = (err_q != ERR_NONE);
  assign status_o.div_zero  = (right_q == '0);
  assign status_o.fact_neg  = right_q[WORD_W-1];
  assign status_o.div_last  = (it_q == ITER_W'(DIV_STEPS - 1));
  assign status_o.fact_done = fact_big || (it_q > right_q[ITER_W-1:0]);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign answer_o     = answer_q;
  assign status_out_o = status_q;

endmodule

// File: hw/rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Each number token is pushed; add, subtract and multiply pop two operands;
//   divide runs a 32-step radix-2 divider; factorial of n from 2 to 33 runs
//   one multiply a cycle, while 0, 1 or 34 and up skip the loop. A last token
//   adds the stack read-out, held while an earlier result still waits.
// Throughput: one item at a time; the output register lets the next item in
//   while a result waits. Reset clears the stack count and error, no sweep.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] token_value_i,
  input  logic               last_token_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] answer_o,
  output logic [1:0]         status_o
);
  import rpn_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .kind_i        (kind_i),
    .token_value_i (token_value_i),
    .last_token_i  (last_token_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .answer_o      (answer_o),
    .status_out_o  (status_o)
  );

endmodule
